// ===== rtl/sfp_pkg.sv =====
// Package with the shared types and character codes of the sensor frame parser.
package sfp_pkg;

   // Character codes the parser reacts to.
   localparam logic [7:0] CH_OPEN_BRACKET  = 8'h5B;  // '['
   localparam logic [7:0] CH_CLOSE_BRACKET = 8'h5D;  // ']'
   localparam logic [7:0] CH_OPEN_PAREN    = 8'h28;  // '('
   localparam logic [7:0] CH_CLOSE_PAREN   = 8'h29;  // ')'
   localparam logic [7:0] CH_SEMICOLON     = 8'h3B;  // ';'
   localparam logic [7:0] CH_MINUS         = 8'h2D;  // '-'
   localparam logic [7:0] CH_ZERO          = 8'h30;  // '0'
   localparam logic [7:0] CH_NINE          = 8'h39;  // '9'
   localparam logic [7:0] CH_UPPER_I       = 8'h49;
   localparam logic [7:0] CH_UPPER_R       = 8'h52;
   localparam logic [7:0] CH_UPPER_U       = 8'h55;
   localparam logic [7:0] CH_UPPER_S       = 8'h53;
   localparam logic [7:0] CH_UPPER_W       = 8'h57;
   localparam logic [7:0] CH_UPPER_C       = 8'h43;

   // Ultrasonic sensor ids that map to configured slots.
   localparam logic [31:0] US_ID_FRONT_CENTER = 32'd226;
   localparam logic [31:0] US_ID_FRONT_RIGHT  = 32'd228;
   localparam logic [31:0] US_ID_REAR_RIGHT   = 32'd230;

   // Wheel group value positions and saturation point of the value counter.
   localparam logic [2:0] WC_PATH_POS  = 3'd1;
   localparam logic [2:0] WC_SPEED_POS = 3'd3;
   localparam logic [2:0] WC_MIN_COUNT = 3'd4;

   // Reset values of the slot registers.
   localparam logic [7:0] FRONT_CENTER_RESET = 8'd3;
   localparam logic [7:0] FRONT_RIGHT_RESET  = 8'd4;
   localparam logic [7:0] REAR_RIGHT_RESET   = 8'd5;

   typedef enum logic [1:0] {
      CSR_FRONT_CENTER = 2'd0,
      CSR_FRONT_RIGHT  = 2'd1,
      CSR_REAR_RIGHT   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_FRAME_END = 2'd0,
      KIND_SENSOR    = 2'd1,
      KIND_ODOMETRY  = 2'd2
   } record_kind_type;

   typedef enum logic [2:0] {
      PH_OUTSIDE = 3'd0,
      PH_LABEL1  = 3'd1,
      PH_LABEL2  = 3'd2,
      PH_BODY    = 3'd3,
      PH_SKIP    = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      GK_NONE  = 3'd0,
      GK_IR    = 3'd1,
      GK_US    = 3'd2,
      GK_WC    = 3'd3,
      GK_OTHER = 3'd4
   } group_kind_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [1:0]         record_kind;
      logic [31:0]        sensor_slot;
      logic signed [31:0] sensor_value;
      logic signed [31:0] odo_speed;
      logic signed [31:0] odo_path;
      logic               frame_end;
   } rsp_type;

   typedef struct packed {
      logic [7:0] front_center_slot;
      logic [7:0] front_right_slot;
      logic [7:0] rear_right_slot;
   } slots_type;

endpackage

// ===== rtl/sfp_csr.sv =====
// Slot configuration registers of the sensor frame parser.
module sfp_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata,
   output sfp_pkg::slots_type slots
);
   import sfp_pkg::*;

   slots_type slots_ff;
   slots_type slots_in;

   always_comb begin
      slots_in = slots_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FRONT_CENTER: slots_in.front_center_slot = csr_wdata;
            CSR_FRONT_RIGHT:  slots_in.front_right_slot  = csr_wdata;
            CSR_REAR_RIGHT:   slots_in.rear_right_slot   = csr_wdata;
            default:          slots_in = slots_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff.front_center_slot <= FRONT_CENTER_RESET;
         slots_ff.front_right_slot  <= FRONT_RIGHT_RESET;
         slots_ff.rear_right_slot   <= REAR_RIGHT_RESET;
      end else begin
         slots_ff <= slots_in;
      end
   end

   assign slots = slots_ff;

endmodule

// ===== rtl/sfp_parser.sv =====
// Parser state and the per-character step that yields at most one result.
module sfp_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  sfp_pkg::req_type   char_in,
   input  sfp_pkg::slots_type slots,
   output logic               result_valid,
   output sfp_pkg::rsp_type   result
);
   import sfp_pkg::*;

   phase_type      phase_ff, phase_in;
   logic [7:0]     label_first_ff, label_first_in;
   group_kind_type kind_ff, kind_in;
   logic [31:0]    acc_ff, acc_in;
   logic           neg_ff, neg_in;
   logic [31:0]    pair_id_ff, pair_id_in;
   logic [2:0]     count_ff, count_in;
   logic [31:0]    path_ff, path_in;
   logic [31:0]    speed_ff, speed_in;

   logic [7:0]  c;
   logic [31:0] sval;
   logic [31:0] acc_times_ten;
   logic [7:0]  digit;
   logic        clear_req;
   logic        start_req;
   group_kind_type label_kind;

   assign c             = char_in.char_code;
   assign sval          = neg_ff ? (32'd0 - acc_ff) : acc_ff;
   assign digit         = c - CH_ZERO;
   assign acc_times_ten = {acc_ff[28:0], 3'b000} + {acc_ff[30:0], 1'b0};

   always_comb begin
      if (label_first_ff == CH_UPPER_I && c == CH_UPPER_R) begin
         label_kind = GK_IR;
      end else if (label_first_ff == CH_UPPER_U && c == CH_UPPER_S) begin
         label_kind = GK_US;
      end else if (label_first_ff == CH_UPPER_W && c == CH_UPPER_C) begin
         label_kind = GK_WC;
      end else begin
         label_kind = GK_OTHER;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      label_first_in = label_first_ff;
      kind_in        = kind_ff;
      acc_in         = acc_ff;
      neg_in         = neg_ff;
      pair_id_in     = pair_id_ff;
      count_in       = count_ff;
      path_in        = path_ff;
      speed_in       = speed_ff;
      result         = '0;
      result_valid   = 1'b0;
      clear_req      = 1'b0;
      start_req      = 1'b0;

      if (phase_ff == PH_LABEL1) begin
         label_first_in = c;
         phase_in       = PH_LABEL2;
      end else if (phase_ff == PH_LABEL2) begin
         kind_in  = label_kind;
         phase_in = PH_BODY;
      end else if (c == CH_OPEN_BRACKET) begin
         clear_req = 1'b1;
         start_req = 1'b1;
      end else if (phase_ff == PH_OUTSIDE) begin
         result_valid = 1'b0;
      end else if (c == CH_CLOSE_BRACKET) begin
         if (kind_ff == GK_WC && count_ff >= WC_MIN_COUNT) begin
            result_valid       = 1'b1;
            result.record_kind = KIND_ODOMETRY;
            result.odo_speed   = speed_ff;
            result.odo_path    = path_ff;
         end
         clear_req = 1'b1;
      end else if (phase_ff == PH_SKIP) begin
         phase_in = PH_BODY;
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
         acc_in = acc_times_ten + {24'd0, digit};
      end else if (c == CH_MINUS) begin
         neg_in = 1'b1;
      end else if (c == CH_OPEN_PAREN) begin
         acc_in = '0;
         neg_in = 1'b0;
      end else if (kind_ff == GK_IR || kind_ff == GK_US) begin
         if (c == CH_SEMICOLON) begin
            pair_id_in = sval;
            acc_in     = '0;
            neg_in     = 1'b0;
         end else if (c == CH_CLOSE_PAREN) begin
            result.record_kind  = KIND_SENSOR;
            result.sensor_value = sval;
            if (kind_ff == GK_IR) begin
               result_valid       = 1'b1;
               result.sensor_slot = pair_id_ff;
            end else if (pair_id_ff == US_ID_FRONT_CENTER) begin
               result_valid       = 1'b1;
               result.sensor_slot = {24'd0, slots.front_center_slot};
            end else if (pair_id_ff == US_ID_FRONT_RIGHT) begin
               result_valid       = 1'b1;
               result.sensor_slot = {24'd0, slots.front_right_slot};
            end else if (pair_id_ff == US_ID_REAR_RIGHT) begin
               result_valid       = 1'b1;
               result.sensor_slot = {24'd0, slots.rear_right_slot};
            end
            acc_in     = '0;
            neg_in     = 1'b0;
            pair_id_in = '0;
            phase_in   = PH_SKIP;
         end
      end else if (c == CH_SEMICOLON || c == CH_CLOSE_PAREN) begin
         if (count_ff == WC_PATH_POS) begin
            path_in = sval;
         end else if (count_ff == WC_SPEED_POS) begin
            speed_in = sval;
         end
         if (count_ff < WC_MIN_COUNT) begin
            count_in = count_ff + 3'd1;
         end
         acc_in = '0;
         neg_in = 1'b0;
      end

      // The final character of a report always yields a result that closes the frame.
      if (char_in.last_char) begin
         if (!result_valid) begin
            result = '0;
         end
         result_valid     = 1'b1;
         result.frame_end = 1'b1;
         clear_req        = 1'b1;
      end

      if (clear_req) begin
         phase_in       = PH_OUTSIDE;
         label_first_in = '0;
         kind_in        = GK_NONE;
         acc_in         = '0;
         neg_in         = 1'b0;
         pair_id_in     = '0;
         count_in       = '0;
         path_in        = '0;
         speed_in       = '0;
      end
      if (start_req && !char_in.last_char) begin
         phase_in = PH_LABEL1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_OUTSIDE;
         label_first_ff <= '0;
         kind_ff        <= GK_NONE;
         acc_ff         <= '0;
         neg_ff         <= 1'b0;
         pair_id_ff     <= '0;
         count_ff       <= '0;
         path_ff        <= '0;
         speed_ff       <= '0;
      end else if (step_en) begin
         phase_ff       <= phase_in;
         label_first_ff <= label_first_in;
         kind_ff        <= kind_in;
         acc_ff         <= acc_in;
         neg_ff         <= neg_in;
         pair_id_ff     <= pair_id_in;
         count_ff       <= count_in;
         path_ff        <= path_in;
         speed_ff       <= speed_in;
      end
   end

   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      count_ff <= WC_MIN_COUNT)
      else $error("wheel value counter passed its saturation point");

   a_last_char_closes: assert property (@(posedge clock) disable iff (reset)
      (step_en && char_in.last_char) |-> (result_valid && result.frame_end))
      else $error("final character did not produce a frame end result");

   a_last_char_clears: assert property (@(posedge clock) disable iff (reset)
      (step_en && char_in.last_char) |=>
         (phase_ff == PH_OUTSIDE && count_ff == 3'd0 && acc_ff == 32'd0))
      else $error("parser state not cleared after the final character");

   a_odometry_needs_wc: assert property (@(posedge clock) disable iff (reset)
      (result_valid && result.record_kind == KIND_ODOMETRY) |->
         (kind_ff == GK_WC && count_ff == WC_MIN_COUNT))
      else $error("odometry record outside a complete wheel group");

endmodule

// ===== rtl/sensor_frame_parser.sv =====
// Top level of the sensor frame parser: input register, parser step and result register.
//
// The block takes a text sensor report one character per transaction on the req_ channel
// and emits sensor readings, odometry records and frame end markers on the rsp_ channel.
// Both channels use valid/ready; a transaction completes on a clock edge where both are high.
// The csr_ channel writes the three ultrasonic slot registers; it is always ready and is
// meant to be written only while no characters are in flight.
//
// Data path: an accepted character waits in the input register until the parser step
// advances, which parses it and writes its result (if any) into the result register; the
// result is presented on rsp_ from there until its own transaction completes.
// Throughput: one character per cycle while the receiver does not stall, set by the single
// parser step between the input and result registers; characters that produce no result
// simply pass through the parser.
// When the receiver stalls, the result register holds its transaction and the parser step
// waits; the input register still takes one more character, after which req_ready drops
// until the result is taken.
// Reset (synchronous, active high) empties both registers, returns the parser to the
// outside-group state and restores slots 3, 4 and 5 for ids 226, 228 and 230.
module sensor_frame_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sfp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sfp_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [7:0]       csr_wdata
);
   import sfp_pkg::*;

   logic      in_valid_ff, in_valid_in;
   req_type   in_data_ff;
   logic      out_valid_ff, out_valid_in;
   rsp_type   out_data_ff;

   logic      advance;
   logic      result_valid;
   rsp_type   result;
   slots_type slots;

   // The parser advances when a character is held and the result register can take a result.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   sfp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .slots     (slots)
   );

   sfp_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .char_in      (in_data_ff),
      .slots        (slots),
      .result_valid (result_valid),
      .result       (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = result_valid;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance && result_valid) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
